// ===== rtl/pceu_pkg.sv =====
// Package for the pixel color effect unit: pixel payload structs, register
// and effect codes, fixed-point coefficients and the 8-bit clamp.
// No dependencies.
`default_nettype none

package pceu_pkg;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEPIA_MIX         = 3'd4;

	// Effect codes held in the mode register.
	localparam logic [2:0] MODE_BRIGHTNESS = 3'd0;
	localparam logic [2:0] MODE_CONTRAST   = 3'd1;
	localparam logic [2:0] MODE_GRAYSCALE  = 3'd2;
	localparam logic [2:0] MODE_SATURATION = 3'd3;
	localparam logic [2:0] MODE_SEPIA      = 3'd4;
	localparam logic [2:0] MODE_INVERT     = 3'd5;

	// Register reset values.
	localparam logic [2:0]  RST_EFFECT_MODE       = MODE_CONTRAST;
	localparam logic [8:0]  RST_BRIGHTNESS_OFFSET = 9'd0;
	localparam logic [11:0] RST_CONTRAST_GAIN     = 12'd256;
	localparam logic [11:0] RST_SATURATION_GAIN   = 12'd256;
	localparam logic [8:0]  RST_SEPIA_MIX         = 9'd256;

	// Full sepia blend; larger register values saturate to this.
	localparam logic [8:0] SEPIA_FULL = 9'd256;

	// Luma weights in Q0.16, red, green, blue.
	localparam logic [15:0] LUMA_COEF [3] = '{16'd19595, 16'd38470, 16'd7471};

	// Sepia matrix in Q0.16, one row per output channel.
	localparam logic [15:0] SEPIA_COEF [3][3] = '{
		'{16'd25756, 16'd50397, 16'd12386},
		'{16'd22872, 16'd44958, 16'd11010},
		'{16'd17826, 16'd34996, 16'd8585}
	};

	localparam int CLAMP_W = 64;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       frame_end_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end_out;
	} pix_out_t;

	// Clamps a signed value to 0..255.
	function automatic logic [7:0] clamp_u8(input logic signed [CLAMP_W-1:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_color_effect_unit_top.sv =====
// Pixel color effect unit: four-stage pipeline with configuration registers.
// An accepted pixel passes through the stage 1, 2, 3 and 4 registers, and the
// stage 4 register drives dst. Throughput: one pixel per cycle while dst_stall
// is low, set by the fully pipelined per-channel multipliers.
// Reset: arst_n clears all valid bits and loads the register reset values.
// Depends on pceu_pkg.
`default_nettype none

module pixel_color_effect_unit_top import pceu_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  pix_in_t               src_data,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output pix_out_t              dst_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Width of the saturation sum: the luma term scaled by the gain fraction
	// plus the signed chroma product, whose magnitude stays below 2^36.
	localparam int SAT_W  = ((25 + GAIN_FRAC_BITS) > 38 ? (25 + GAIN_FRAC_BITS) : 38) + 1;
	localparam int SATP_W = 39;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are taken in any cycle; the user must write
	// them only while the pipeline is empty (the block does not enforce this), as
	// every stage reads them directly without a per-pixel snapshot.
	// ------------------------------------------------------------------
	logic [2:0]  mode_q;
	logic [8:0]  bright_q;
	logic [11:0] cgain_q;
	logic [11:0] sgain_q;
	logic [8:0]  smix_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_EFFECT_MODE;
			bright_q <= RST_BRIGHTNESS_OFFSET;
			cgain_q  <= RST_CONTRAST_GAIN;
			sgain_q  <= RST_SATURATION_GAIN;
			smix_q   <= RST_SEPIA_MIX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EFFECT_MODE:       mode_q   <= cfg_data[2:0];
				REG_BRIGHTNESS_OFFSET: bright_q <= cfg_data[8:0];
				REG_CONTRAST_GAIN:     cgain_q  <= cfg_data[11:0];
				REG_SATURATION_GAIN:   sgain_q  <= cfg_data[11:0];
				REG_SEPIA_MIX:         smix_q   <= cfg_data[8:0];
				default: begin
					// Indexes past the register list are dropped.
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control. Each stage loads when it is empty or when the stage
	// after it moves on, so bubbles are squeezed out and a stall at the
	// output only backs up as far as the pipeline is full.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4     = !v_s4 || !dst_stall;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign src_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= src_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: all per-pixel products that only need the input channels:
	// the three luma terms, the nine sepia matrix terms and the contrast
	// product about mid-gray for each channel.
	// ------------------------------------------------------------------
	logic [7:0]         c_in [3];
	logic signed [8:0]  cdiff [3];
	logic signed [20:0] cgain_s;

	logic [7:0]         c_s1 [3];
	logic               fe_s1;
	logic [23:0]        lum_p_s1 [3];
	logic [23:0]        sep_p_s1 [3][3];
	logic signed [20:0] con_p_s1 [3];

	assign c_in[0] = src_data.red_in;
	assign c_in[1] = src_data.green_in;
	assign c_in[2] = src_data.blue_in;
	assign cgain_s = signed'({9'd0, cgain_q});

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cdiff[k] = signed'({1'b0, c_in[k]}) - 9'sd128;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			fe_s1 <= src_data.frame_end_in;
			for (int k = 0; k < 3; k++) begin
				c_s1[k]     <= c_in[k];
				lum_p_s1[k] <= 24'(LUMA_COEF[k]) * 24'(c_in[k]);
				con_p_s1[k] <= 21'(cdiff[k]) * cgain_s;
				for (int j = 0; j < 3; j++) begin
					sep_p_s1[k][j] <= 24'(SEPIA_COEF[k][j]) * 24'(c_in[j]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: luma sum, sepia targets (not clamped) and the finished
	// contrast result, which is floored, re-centered and clamped here.
	// ------------------------------------------------------------------
	logic [24:0]        sep_sum [3];
	logic signed [20:0] con_v [3];

	logic [7:0]         c_s2 [3];
	logic               fe_s2;
	logic [23:0]        luma_s2;
	logic [8:0]         tgt_s2 [3];
	logic [7:0]         con_s2 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sep_sum[k] = 25'(sep_p_s1[k][0]) + 25'(sep_p_s1[k][1]) + 25'(sep_p_s1[k][2]);
			con_v[k]   = (con_p_s1[k] >>> GAIN_FRAC_BITS) + 21'sd128;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			fe_s2   <= fe_s1;
			luma_s2 <= lum_p_s1[0] + lum_p_s1[1] + lum_p_s1[2];
			for (int k = 0; k < 3; k++) begin
				c_s2[k]   <= c_s1[k];
				tgt_s2[k] <= sep_sum[k][24:16];
				con_s2[k] <= clamp_u8(CLAMP_W'(con_v[k]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: the saturation chroma product (channel minus luma, times the
	// gain) and the sepia blend product (target minus channel, times the
	// saturated mix amount).
	// ------------------------------------------------------------------
	logic [8:0]               mix_sat;
	logic signed [25:0]       chroma [3];
	logic signed [9:0]        tdiff [3];
	logic signed [SATP_W-1:0] sgain_s;
	logic signed [19:0]       mix_s;

	logic [7:0]               c_s3 [3];
	logic                     fe_s3;
	logic [23:0]              luma_s3;
	logic [7:0]               con_s3 [3];
	logic signed [SATP_W-1:0] sat_p_s3 [3];
	logic signed [19:0]       sep_p_s3 [3];

	assign mix_sat = (smix_q > SEPIA_FULL) ? SEPIA_FULL : smix_q;
	assign sgain_s = signed'({{(SATP_W-12){1'b0}}, sgain_q});
	assign mix_s   = signed'({11'd0, mix_sat});

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			chroma[k] = signed'({2'b00, c_s2[k], 16'd0}) - signed'({2'b00, luma_s2});
			tdiff[k]  = signed'({1'b0, tgt_s2[k]}) - signed'({2'b00, c_s2[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			fe_s3   <= fe_s2;
			luma_s3 <= luma_s2;
			for (int k = 0; k < 3; k++) begin
				c_s3[k]     <= c_s2[k];
				con_s3[k]   <= con_s2[k];
				sat_p_s3[k] <= SATP_W'(chroma[k]) * sgain_s;
				sep_p_s3[k] <= 20'(tdiff[k]) * mix_s;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: final adds, floors and clamps, then the effect select into
	// the output register. Unused mode codes pass the pixel through.
	// ------------------------------------------------------------------
	logic [SAT_W-1:0]        luma_sh;
	logic signed [SAT_W-1:0] sat_sum [3];
	logic signed [SAT_W-1:0] sat_v [3];
	logic signed [19:0]      sep_v [3];
	logic signed [10:0]      bri_v [3];
	logic [7:0]              res [3];

	assign luma_sh = SAT_W'(luma_s3) << GAIN_FRAC_BITS;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sat_sum[k] = signed'(luma_sh) + SAT_W'(sat_p_s3[k]);
			sat_v[k]   = sat_sum[k] >>> (16 + GAIN_FRAC_BITS);
			sep_v[k]   = signed'({12'd0, c_s3[k]}) + (sep_p_s3[k] >>> 8);
			bri_v[k]   = signed'({3'd0, c_s3[k]}) + 11'(signed'(bright_q));
			case (mode_q)
				MODE_BRIGHTNESS: res[k] = clamp_u8(CLAMP_W'(bri_v[k]));
				MODE_CONTRAST:   res[k] = con_s3[k];
				MODE_GRAYSCALE:  res[k] = luma_s3[23:16];
				MODE_SATURATION: res[k] = clamp_u8(CLAMP_W'(sat_v[k]));
				MODE_SEPIA:      res[k] = clamp_u8(CLAMP_W'(sep_v[k]));
				MODE_INVERT:     res[k] = 8'd255 - c_s3[k];
				default:         res[k] = c_s3[k];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			dst_data.red_out       <= res[0];
			dst_data.green_out     <= res[1];
			dst_data.blue_out      <= res[2];
			dst_data.frame_end_out <= fe_s3;
		end
	end

	assign dst_valid = v_s4;

endmodule

`default_nettype wire

// ===== rtl/pceu_checker.sv =====
// Port-level checker for the pixel color effect unit, with its bind.
// Depends on pceu_pkg and binds to pixel_color_effect_unit_top.
`default_nettype none

module pceu_checker import pceu_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  src_valid,
	input wire logic                  src_stall,
	input wire pix_in_t               src_data,
	input wire logic                  dst_valid,
	input wire logic                  dst_stall,
	input wire pix_out_t              dst_data,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	// A held result keeps its value until it transfers.
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("result changed while stalled");

	// The input only stalls when the whole pipeline is full and blocked.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid && dst_stall)
		else $error("input stalled with room in the pipeline");

	// With a free output, an accepted pixel reaches the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) ##1 !dst_stall ##1 !dst_stall ##1 !dst_stall
		|=> dst_valid)
		else $error("accepted pixel did not reach the output");

	// Register writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was refused");

endmodule

bind pixel_color_effect_unit_top pceu_checker u_pceu_checker (.*);

`default_nettype wire

// ===== bench/tb_pixel_color_effect_unit_top.sv =====
// Self-checking bench for pixel_color_effect_unit_top: drives pixels under many register
// settings and compares every result with a recoloring predictor held in the bench.
// Depends on pceu_pkg and the RTL of the unit; reads no files.

module tb_pixel_color_effect_unit_top;
	import pceu_pkg::*;

	// The bench predicts for the default fraction width of the gains.
	localparam int GAIN_FRAC = 8;

	// Mode codes that select no effect; the unit passes the pixel through.
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	// Luma weights in Q0.16.
	localparam longint LUMA_R_Q16 = 19595;
	localparam longint LUMA_G_Q16 = 38470;
	localparam longint LUMA_B_Q16 = 7471;

	// Register extremes used by the directed and random parts.
	localparam logic [8:0]  OFFSET_MINUS_256 = 9'h100;
	localparam logic [8:0]  OFFSET_MINUS_255 = 9'h101;
	localparam logic [8:0]  OFFSET_PLUS_255  = 9'h0FF;
	localparam logic [11:0] GAIN_MAX         = 12'hFFF;
	localparam int          SEPIA_FULL_MIX   = 256;
	localparam logic [8:0]  SEPIA_OVER_FULL  = 9'h1FF;

	// Two corner pixels that put 0 and 255 on red and green between them, and 0x80 and 0x7F on blue.
	localparam pix_in_t PIX_CORNER_A = {8'hFF, 8'h00, 8'h80, 1'b1};
	localparam pix_in_t PIX_CORNER_B = {8'h00, 8'hFF, 8'h7F, 1'b0};

	localparam int MAX_WAIT        = 10;
	localparam int SETTLE_CYCLES   = 8;    // a little over the four-stage latency
	localparam int PRESSURE_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_PIXELS    = 72;
	localparam int PRESSURE_PIXELS = 60;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_stall;
	pix_in_t               src_data;
	logic                  dst_valid;
	logic                  dst_stall;
	pix_out_t              dst_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// The bench's own copy of the configuration registers.
	logic [2:0]  eff_mode   = RST_EFFECT_MODE;
	logic [8:0]  bright_off = RST_BRIGHTNESS_OFFSET;
	logic [11:0] contrast_g = RST_CONTRAST_GAIN;
	logic [11:0] satur_g    = RST_SATURATION_GAIN;
	logic [8:0]  sepia_amt  = RST_SEPIA_MIX;

	// Recolored pixels still owed by the unit, oldest first.
	pix_out_t expected_pixels [$];

	int unsigned error_count     = 0;
	int unsigned idle_cycles     = 0;
	int unsigned pressure_cycles = 0;
	bit          no_gaps         = 1'b0;

	pixel_color_effect_unit_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// Computes the recolored pixel under the current register copy. All the math is done
	// in signed 64-bit values, so an arithmetic right shift is a floored division.
	function automatic pix_out_t predict_recolor(input pix_in_t p);
		longint     chan [3];
		longint     luma, off, mix, cg, sg, tone, v;
		logic [7:0] res [3];
		pix_out_t   r;
		chan[0] = longint'(p.red_in);
		chan[1] = longint'(p.green_in);
		chan[2] = longint'(p.blue_in);
		luma = LUMA_R_Q16 * chan[0] + LUMA_G_Q16 * chan[1] + LUMA_B_Q16 * chan[2];
		// The offset is a 9-bit two's complement value, so 0x100 means -256.
		off = longint'(bright_off);
		if (bright_off[8]) begin
			off = off - 512;
		end
		// Mix values above full sepia saturate to full.
		mix = longint'(sepia_amt);
		if (mix > SEPIA_FULL_MIX) begin
			mix = SEPIA_FULL_MIX;
		end
		cg = longint'(contrast_g);
		sg = longint'(satur_g);
		for (int k = 0; k < 3; k++) begin
			case (eff_mode)
				MODE_BRIGHTNESS: begin
					v = chan[k] + off;
				end
				MODE_CONTRAST: begin
					v = (((chan[k] - 128) * cg) >>> GAIN_FRAC) + 128;
				end
				MODE_GRAYSCALE: begin
					v = luma >>> 16;
				end
				MODE_SATURATION: begin
					v = ((luma <<< GAIN_FRAC) + (chan[k] * 65536 - luma) * sg)
						>>> (16 + GAIN_FRAC);
				end
				MODE_SEPIA: begin
					// The sepia tone is not clamped before the blend.
					case (k)
						0: tone = 25756 * chan[0] + 50397 * chan[1] + 12386 * chan[2];
						1: tone = 22872 * chan[0] + 44958 * chan[1] + 11010 * chan[2];
						default: tone = 17826 * chan[0] + 34996 * chan[1] + 8585 * chan[2];
					endcase
					tone = tone >>> 16;
					v = chan[k] + (((tone - chan[k]) * mix) >>> 8);
				end
				MODE_INVERT: begin
					v = 255 - chan[k];
				end
				default: begin
					v = chan[k];
				end
			endcase
			res[k] = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
		end
		r.red_out       = res[0];
		r.green_out     = res[1];
		r.blue_out      = res[2];
		r.frame_end_out = p.frame_end_in;
		return r;
	endfunction

	// Wait drawn for each item by both sides; zero while a no-idle stretch is running.
	function automatic int unsigned draw_wait();
		return no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	// Offers one pixel after a random gap and returns at the edge of its transfer.
	// Valid stays high after the transfer, so the caller must either send the next
	// pixel or close the stream without letting time pass.
	task automatic send_pixel(input pix_in_t pix);
		int unsigned gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= pix;
		do @(posedge clk); while (src_stall);
		expected_pixels.push_back(predict_recolor(pix));
	endtask

	task automatic end_stream();
		@(negedge clk);
		src_valid <= 1'b0;
	endtask

	// Writes one register once the unit has drained, then updates the bench's copy.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		end_stream();
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_EFFECT_MODE:       eff_mode   = value[2:0];
			REG_BRIGHTNESS_OFFSET: bright_off = value[8:0];
			REG_CONTRAST_GAIN:     contrast_g = value[11:0];
			REG_SATURATION_GAIN:   satur_g    = value[11:0];
			REG_SEPIA_MIX:         sepia_amt  = value[8:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A few pixels under the reset configuration: contrast mode at unity gain.
	task automatic test_reset_values();
		send_pixel({8'h00, 8'h00, 8'h00, 1'b0});
		send_pixel({8'hFF, 8'hFF, 8'hFF, 1'b1});
		send_pixel({8'h80, 8'h7F, 8'h01, 1'b0});
	endtask

	// Every mode code, the two spare ones included, on both corner pixels.
	task automatic test_each_effect();
		for (int m = MODE_BRIGHTNESS; m <= MODE_SPARE_HI; m++) begin
			write_register(REG_EFFECT_MODE, CFG_DATA_W'(m));
			send_pixel(PIX_CORNER_A);
			send_pixel(PIX_CORNER_B);
		end
	endtask

	// Register values at their limits: the offset of -256, a sepia mix above full,
	// no sepia at all, and the largest contrast and saturation gains.
	task automatic test_register_extremes();
		write_register(REG_EFFECT_MODE, CFG_DATA_W'(MODE_BRIGHTNESS));
		write_register(REG_BRIGHTNESS_OFFSET, CFG_DATA_W'(OFFSET_MINUS_256));
		send_pixel({8'hC8, 8'hFF, 8'h00, 1'b1});
		write_register(REG_EFFECT_MODE, CFG_DATA_W'(MODE_SEPIA));
		write_register(REG_SEPIA_MIX, CFG_DATA_W'(SEPIA_OVER_FULL));
		send_pixel(PIX_CORNER_A);
		write_register(REG_SEPIA_MIX, '0);
		send_pixel(PIX_CORNER_B);
		write_register(REG_EFFECT_MODE, CFG_DATA_W'(MODE_CONTRAST));
		write_register(REG_CONTRAST_GAIN, GAIN_MAX);
		send_pixel({8'hFF, 8'h00, 8'h81, 1'b0});
		write_register(REG_EFFECT_MODE, CFG_DATA_W'(MODE_SATURATION));
		write_register(REG_SATURATION_GAIN, GAIN_MAX);
		send_pixel(PIX_CORNER_A);
	endtask

	// Writes to the indexes past the last register must leave every register alone.
	task automatic test_unknown_index();
		for (int i = REG_SEPIA_MIX + 1; i < 2 ** CFG_IDX_W; i++) begin
			write_register(CFG_IDX_W'(i),
				CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1)));
		end
		send_pixel(PIX_CORNER_B);
	endtask

	// Random register settings, each followed by a run of random pixels. Every fourth
	// phase runs with no idling on either side.
	task automatic test_random_phases();
		logic [CFG_DATA_W-1:0] value;
		logic [31:0]           bits;
		int unsigned           sel;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int i = REG_EFFECT_MODE; i <= REG_SEPIA_MIX; i++) begin
				sel   = $urandom_range(0, 3);
				value = CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
				case (i)
					REG_BRIGHTNESS_OFFSET: begin
						if (sel == 0) value = CFG_DATA_W'(OFFSET_MINUS_255);
						if (sel == 1) value = CFG_DATA_W'(OFFSET_PLUS_255);
					end
					REG_CONTRAST_GAIN, REG_SATURATION_GAIN: begin
						if (sel == 0) value = '0;
						if (sel == 1) value = GAIN_MAX;
					end
					REG_SEPIA_MIX: begin
						if (sel == 0) value = '0;
						if (sel == 1) value = CFG_DATA_W'(SEPIA_FULL_MIX);
					end
					default: ;
				endcase
				write_register(CFG_IDX_W'(i), value);
			end
			no_gaps = (ph % 4 == 3);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				bits = $urandom;
				send_pixel(bits[$bits(pix_in_t)-1:0]);
			end
			no_gaps = 1'b0;
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering pixels
	// back to back, so the pipeline fills and the unit has to stall its input.
	task automatic test_backpressure();
		logic [31:0] bits;
		write_register(REG_EFFECT_MODE, CFG_DATA_W'(MODE_SATURATION));
		no_gaps = 1'b1;
		pressure_cycles = PRESSURE_CYCLES;
		for (int n = 0; n < PRESSURE_PIXELS; n++) begin
			bits = $urandom;
			send_pixel(bits[$bits(pix_in_t)-1:0]);
		end
		no_gaps = 1'b0;
	endtask

	// Receiver: for each result it stalls a drawn number of cycles, then waits for the
	// transfer. A pending hold-off request is served before the next draw.
	initial begin
		int unsigned n;
		dst_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_cycles > 0) begin
				n = pressure_cycles;
				pressure_cycles = 0;
				dst_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			n = draw_wait();
			if (n > 0) begin
				dst_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			dst_stall <= 1'b0;
			do @(posedge clk); while (!dst_valid);
		end
	end

	// Every result transfer is matched against the oldest expected pixel.
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %h with no pixel outstanding", dst_data));
			end else begin
				want = expected_pixels.pop_front();
				if (dst_data.red_out !== want.red_out)
					report_mismatch($sformatf("red_out %0d, expected %0d",
						dst_data.red_out, want.red_out));
				if (dst_data.green_out !== want.green_out)
					report_mismatch($sformatf("green_out %0d, expected %0d",
						dst_data.green_out, want.green_out));
				if (dst_data.blue_out !== want.blue_out)
					report_mismatch($sformatf("blue_out %0d, expected %0d",
						dst_data.blue_out, want.blue_out));
				if (dst_data.frame_end_out !== want.frame_end_out)
					report_mismatch($sformatf("frame_end_out %0d, expected %0d",
						dst_data.frame_end_out, want.frame_end_out));
			end
		end
	end

	// Watchdog: counts cycles in which no transfer happens on any channel.
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Main sequence: reset once, run the tests in turn, drain, then give the verdict.
	initial begin
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_data  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_each_effect();
		test_register_extremes();
		test_unknown_index();
		test_random_phases();
		test_backpressure();

		end_stream();
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
